// ===== rtl/char_grid_rotate_reflect_assert.svh =====
// ---------------------------------------------------------------------------
// char_grid_rotate_reflect_assert.svh
// Assertion macros for the character grid block.
// ---------------------------------------------------------------------------
`ifndef CHAR_GRID_ROTATE_REFLECT_ASSERT_SVH
`define CHAR_GRID_ROTATE_REFLECT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked at every edge, reset included.
`define CGRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// Checked outside reset only.
`define CGRR_ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define CGRR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`define CGRR_ASSERT_ON(lbl, clk, rst, prop, msg)
`endif

`endif

// ===== rtl/cgrr_pkg.sv =====
// ---------------------------------------------------------------------------
// cgrr_pkg
// Shared widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package cgrr_pkg;

  localparam int CMD_W       = 2;
  localparam int OP_W        = 2;
  localparam int ROW_W       = 6;
  localparam int CHAR_W      = 8;
  localparam int DIM_PORT_W  = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_DIM_DEF = 64;
  localparam int DIM_RST_DEF = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_XFORM   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [OP_W-1:0] {
    OP_ROT_CW   = 2'd0,
    OP_ROT_CCW  = 2'd1,
    OP_MIR_COLS = 2'd2,
    OP_MIR_ROWS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_XF_RUN,
    ST_XF_LAST
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming word, clear walk counter
    logic exec;       // perform write or restart
    logic xf_step;    // issue one transform read, advance walk
    logic xf_commit;  // swap banks, load new dimensions
    logic finish;     // load result registers
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic xf_last;
  } dp_stat_t;

endpackage

// ===== rtl/cgrr_dpath.sv =====
// ---------------------------------------------------------------------------
// cgrr_dpath
// Grid storage (two banks in one RAM), dimensions, range check and the
// address generator that walks the grid during a transform.
// ---------------------------------------------------------------------------
`include "char_grid_rotate_reflect_assert.svh"

module cgrr_dpath #(
  parameter int MAX_DIM = cgrr_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cgrr_pkg::ctl_cmd_t               ctl,
  output cgrr_pkg::dp_stat_t               stat,
  input  logic [cgrr_pkg::CMD_W-1:0]       cmd,
  input  logic [cgrr_pkg::OP_W-1:0]        op,
  input  logic [cgrr_pkg::ROW_W-1:0]       row,
  input  logic [cgrr_pkg::ROW_W-1:0]       col,
  input  logic [cgrr_pkg::CHAR_W-1:0]      char_in,
  input  logic                             cfg_we,
  input  logic [cgrr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cgrr_pkg::DIM_PORT_W-1:0]  cfg_wdata,
  output logic [cgrr_pkg::CHAR_W-1:0]      char_out,
  output logic [cgrr_pkg::DIM_PORT_W-1:0]  cur_width,
  output logic [cgrr_pkg::DIM_PORT_W-1:0]  cur_height,
  output logic                             status
);
  import cgrr_pkg::*;

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CMP_W     = (DIM_W > DIM_PORT_W) ? DIM_W : DIM_PORT_W;
  localparam int CNT_W     = 2 * IDX_W;
  localparam int ADDR_W    = CNT_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int DIM_RST   = (MAX_DIM < DIM_RST_DEF) ? MAX_DIM : DIM_RST_DEF;

  // Saturate a configured dimension to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_PORT_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx == '0) return DIM_W'(1);
    else if (vx > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    else return DIM_W'(vx);
  endfunction

  // Latched word
  cmd_t              cmd_q;
  op_t               op_q;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  col_q;
  logic [CHAR_W-1:0] char_q;

  // Config and grid state
  logic [DIM_PORT_W-1:0] cfg_w;
  logic [DIM_PORT_W-1:0] cfg_h;
  logic [DIM_W-1:0]      cur_w;
  logic [DIM_W-1:0]      cur_h;
  logic                  bank;

  // Transform walk
  logic [CNT_W-1:0] cnt;
  logic             wr_pend;
  logic [CNT_W-1:0] wr_addr_d;

  // Storage
  logic [CHAR_W-1:0] mem [MEM_DEPTH];
  logic [CHAR_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  // Result registers
  logic [CHAR_W-1:0] char_out_q;
  logic              status_q;

  // Combinational helpers
  logic [CMP_W-1:0] row_x;
  logic [CMP_W-1:0] col_x;
  logic             oob;
  logic [CNT_W-1:0] acc_addr;
  logic [IDX_W-1:0] xr;
  logic [IDX_W-1:0] xc;
  logic             rot;
  logic [DIM_W-1:0] nw;
  logic [DIM_W-1:0] nh;
  logic             in_grid;
  logic [DIM_W-1:0] wm1;
  logic [DIM_W-1:0] hm1;
  logic [DIM_W-1:0] t_h_c;
  logic [DIM_W-1:0] t_w_r;
  logic [DIM_W-1:0] t_w_c;
  logic [DIM_W-1:0] t_h_r;
  logic [CNT_W-1:0] src;

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= cmd_t'(cmd);
      op_q   <= op_t'(op);
      row_q  <= row;
      col_q  <= col;
      char_q <= char_in;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= DIM_PORT_W'(DIM_RST_DEF);
      cfg_h <= DIM_PORT_W'(DIM_RST_DEF);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRID_WIDTH:  cfg_w <= cfg_wdata;
        CFG_GRID_HEIGHT: cfg_h <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Range check and access address
  assign row_x    = CMP_W'(row_q);
  assign col_x    = CMP_W'(col_q);
  assign oob      = (row_x >= CMP_W'(cur_h)) || (col_x >= CMP_W'(cur_w));
  assign acc_addr = {row_x[IDX_W-1:0], col_x[IDX_W-1:0]};

  // Transform source address for destination cell (xr, xc)
  assign xr      = cnt[CNT_W-1:IDX_W];
  assign xc      = cnt[IDX_W-1:0];
  assign rot     = (op_q == OP_ROT_CW) || (op_q == OP_ROT_CCW);
  assign nw      = rot ? cur_h : cur_w;
  assign nh      = rot ? cur_w : cur_h;
  assign in_grid = (DIM_W'(xr) < nh) && (DIM_W'(xc) < nw);
  assign wm1     = cur_w - DIM_W'(1);
  assign hm1     = cur_h - DIM_W'(1);
  assign t_h_c   = hm1 - DIM_W'(xc);
  assign t_w_r   = wm1 - DIM_W'(xr);
  assign t_w_c   = wm1 - DIM_W'(xc);
  assign t_h_r   = hm1 - DIM_W'(xr);

  always_comb begin
    if (!in_grid) begin
      src = cnt;  // outside the new grid: cell keeps its contents
    end else begin
      case (op_q)
        OP_ROT_CW:   src = {t_h_c[IDX_W-1:0], xr};
        OP_ROT_CCW:  src = {xc, t_w_r[IDX_W-1:0]};
        OP_MIR_COLS: src = {xr, t_w_c[IDX_W-1:0]};
        default:     src = {t_h_r[IDX_W-1:0], xc};
      endcase
    end
  end

  // Walk counter and delayed write of the copied cell
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= ctl.xf_step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cnt <= '0;
    end else if (ctl.xf_step) begin
      cnt <= cnt + CNT_W'(1);
    end
    wr_addr_d <= cnt;
  end

  // Dimensions and active bank
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w <= DIM_W'(DIM_RST);
      cur_h <= DIM_W'(DIM_RST);
      bank  <= 1'b0;
    end else if (ctl.xf_commit) begin
      cur_w <= nw;
      cur_h <= nh;
      bank  <= ~bank;
    end else if (ctl.exec && cmd_q == CMD_RESTART) begin
      cur_w <= clamp_dim(cfg_w);
      cur_h <= clamp_dim(cfg_h);
    end
  end

  // RAM port muxing: transform copies write into the idle bank
  assign mem_we    = wr_pend || (ctl.exec && cmd_q == CMD_WRITE && !oob);
  assign mem_waddr = wr_pend ? {~bank, wr_addr_d} : {bank, acc_addr};
  assign mem_wdata = wr_pend ? mem_q : char_q;
  assign mem_raddr = ctl.xf_step ? {bank, src} : {bank, acc_addr};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      char_out_q <= (cmd_q == CMD_READ && !oob) ? mem_q : '0;
      status_q   <= (cmd_q == CMD_WRITE || cmd_q == CMD_READ) && oob;
    end
  end

  assign char_out     = char_out_q;
  assign status       = status_q;
  assign cur_width    = DIM_PORT_W'(cur_w);
  assign cur_height   = DIM_PORT_W'(cur_h);
  assign stat.cmd     = cmd_q;
  assign stat.xf_last = (cnt == '1);

  // Dimensions stay inside the legal range
  `CGRR_ASSERT_ON(a_dims_legal, clk, rst, (cur_w != '0) && (cur_w <= DIM_W'(MAX_DIM)) && (cur_h != '0) && (cur_h <= DIM_W'(MAX_DIM)), "grid dimension out of range")

endmodule

// ===== rtl/cgrr_ctrl.sv =====
// ---------------------------------------------------------------------------
// cgrr_ctrl
// Command sequencer: accepts a word, steps the datapath, strobes done.
// ---------------------------------------------------------------------------
`include "char_grid_rotate_reflect_assert.svh"

module cgrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output cgrr_pkg::ctl_cmd_t  ctl,
  input  cgrr_pkg::dp_stat_t  stat
);
  import cgrr_pkg::*;

  state_t state;
  state_t state_next;
  logic   done_next;

  // State and done strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (stat.cmd)
          CMD_READ:  state_next = ST_RD_WAIT;
          CMD_XFORM: state_next = ST_XF_RUN;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_RD_WAIT: state_next = ST_IDLE;
      ST_XF_RUN: begin
        if (stat.xf_last) state_next = ST_XF_LAST;
      end
      ST_XF_LAST: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: ctl.capture = start;
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        ctl.finish = (stat.cmd == CMD_WRITE) || (stat.cmd == CMD_RESTART);
      end
      ST_RD_WAIT: ctl.finish = 1'b1;
      ST_XF_RUN:  ctl.xf_step = 1'b1;
      ST_XF_LAST: begin
        ctl.xf_commit = 1'b1;
        ctl.finish    = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  assign done_next = ctl.finish;
  assign busy      = (state != ST_IDLE);

  `CGRR_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (!busy && !done), "not idle after reset")
  `CGRR_ASSERT_ON(a_done_idle, clk, rst, done |-> !busy, "done strobe while busy")
  `CGRR_ASSERT_ON(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted word not started")
  `CGRR_ASSERT_ON(a_last_after_run, clk, rst, (state == ST_XF_LAST) |-> ($past(state) == ST_XF_RUN), "transform end without walk")

endmodule

// ===== rtl/char_grid_rotate_reflect.sv =====
// ---------------------------------------------------------------------------
// char_grid_rotate_reflect
// Character grid with cell write/read, restart from config, and rotate /
// mirror transforms.
// A transform copies every cell of the active bank through the single RAM
// write port into the idle bank.
// One word at a time; the next start is taken in the done cycle. done is
// a one-cycle strobe and the receiver cannot stall it.
// Synchronous reset: idle, dimensions and config back to 8; cells undefined.
// ---------------------------------------------------------------------------
module char_grid_rotate_reflect #(
  parameter int MAX_DIM = cgrr_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic [cgrr_pkg::CMD_W-1:0]       cmd,
  input  logic [cgrr_pkg::OP_W-1:0]        op,
  input  logic [cgrr_pkg::ROW_W-1:0]       row,
  input  logic [cgrr_pkg::ROW_W-1:0]       col,
  input  logic [cgrr_pkg::CHAR_W-1:0]      char_in,
  output logic [cgrr_pkg::CHAR_W-1:0]      char_out,
  output logic [cgrr_pkg::DIM_PORT_W-1:0]  cur_width,
  output logic [cgrr_pkg::DIM_PORT_W-1:0]  cur_height,
  output logic                             status,
  input  logic                             cfg_we,
  input  logic [cgrr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cgrr_pkg::DIM_PORT_W-1:0]  cfg_wdata
);
  import cgrr_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Sequencer
  cgrr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .stat  (stat)
  );

  // Storage and datapath
  cgrr_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cmd        (cmd),
    .op         (op),
    .row        (row),
    .col        (col),
    .char_in    (char_in),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .char_out   (char_out),
    .cur_width  (cur_width),
    .cur_height (cur_height),
    .status     (status)
  );

endmodule

// ===== verif/tb_char_grid_rotate_reflect.sv =====
// ----------------------------------------------------------------------------
// tb_char_grid_rotate_reflect
// Self-checking testbench for the character grid block.
// A scoreboard class keeps its own copy of the grid, of the cell write map
// and of the dimensions, and predicts one result word for every accepted
// command word. Directed words cover the edges of the grid, every transform
// and the clamping of the restart dimensions. Random phases then reprogram
// the dimensions, restart, fill the grid and mix reads, writes, transforms,
// restarts and out-of-range accesses, with random gaps on the command side.
// ----------------------------------------------------------------------------
module tb_char_grid_rotate_reflect;
  import cgrr_pkg::*;

  localparam int GRID_DIM     = MAX_DIM_DEF;
  localparam int CELLS        = GRID_DIM * GRID_DIM;
  localparam int RANDOM_WORDS = 1200;
  localparam int XFORM_CAP    = 100;
  localparam int SHOW_ERRORS  = 10;
  localparam logic [CHAR_W-1:0] CH_Y = "y";

  typedef struct packed {
    logic [CHAR_W-1:0]     ch;
    logic [DIM_PORT_W-1:0] w;
    logic [DIM_PORT_W-1:0] h;
    logic                  st;
  } grid_result_t;

  // Grid predictor and store of expected result words
  class grid_scoreboard;
    logic [CHAR_W-1:0] cells [CELLS];
    bit                written [CELLS];
    int unsigned       width_now, height_now, width_reg, height_reg;
    grid_result_t      result_q [$];
    int                errors;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        cells[i]   = '0;
        written[i] = 1'b0;
      end
      width_reg  = DIM_RST_DEF;
      height_reg = DIM_RST_DEF;
      width_now  = clamp_dim(DIM_RST_DEF);
      height_now = clamp_dim(DIM_RST_DEF);
      errors     = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return v;
    endfunction

    function bit is_written(int unsigned r, int unsigned c);
      return written[r * GRID_DIM + c];
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_PORT_W-1:0] v);
      if (idx == CFG_GRID_WIDTH) width_reg = 32'(v);
      else if (idx == CFG_GRID_HEIGHT) height_reg = 32'(v);
    endfunction

    // Whole-grid transform; cells outside the new grid keep their contents
    function void apply_xform(op_t o);
      logic [CHAR_W-1:0] old_cells [CELLS];
      bit                old_written [CELLS];
      int unsigned       w, h, nw, nh, src;
      old_cells   = cells;
      old_written = written;
      w  = width_now;
      h  = height_now;
      nw = w;
      nh = h;
      if (o == OP_ROT_CW || o == OP_ROT_CCW) begin
        nw = h;
        nh = w;
      end
      for (int unsigned r = 0; r < nh; r++) begin
        for (int unsigned c = 0; c < nw; c++) begin
          case (o)
            OP_ROT_CW:   src = (h - 1 - c) * GRID_DIM + r;
            OP_ROT_CCW:  src = c * GRID_DIM + (w - 1 - r);
            OP_MIR_COLS: src = r * GRID_DIM + (w - 1 - c);
            default:     src = (h - 1 - r) * GRID_DIM + c;
          endcase
          cells[r * GRID_DIM + c]   = old_cells[src];
          written[r * GRID_DIM + c] = old_written[src];
        end
      end
      width_now  = nw;
      height_now = nh;
    endfunction

    // Accepted command word: update the grid and queue the expected word
    function void note_word(cmd_t c, op_t o, int unsigned r, int unsigned cl,
                            logic [CHAR_W-1:0] ch);
      grid_result_t res;
      res = '0;
      case (c) inside
        CMD_WRITE, CMD_READ: begin
          if (r >= height_now || cl >= width_now) begin
            res.st = 1'b1;
          end else if (c == CMD_WRITE) begin
            cells[r * GRID_DIM + cl]   = ch;
            written[r * GRID_DIM + cl] = 1'b1;
          end else begin
            res.ch = cells[r * GRID_DIM + cl];
          end
        end
        CMD_XFORM: apply_xform(o);
        default: begin
          width_now  = clamp_dim(width_reg);
          height_now = clamp_dim(height_reg);
        end
      endcase
      res.w = DIM_PORT_W'(width_now);
      res.h = DIM_PORT_W'(height_now);
      result_q.push_back(res);
    endfunction

    function void check_result(grid_result_t got);
      grid_result_t exp_r;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("ERROR: result word with nothing expected: char %02h w %0d h %0d st %0d",
                   got.ch, got.w, got.h, got.st);
        return;
      end
      exp_r = result_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display({"ERROR: char exp %02h got %02h, width exp %0d got %0d, ",
                    "height exp %0d got %0d, status exp %0d got %0d"},
                   exp_r.ch, got.ch, exp_r.w, got.w, exp_r.h, got.h, exp_r.st, got.st);
      end
    endfunction
  endclass

  logic                  clk, rst, start, cfg_we;
  logic [CMD_W-1:0]      cmd;
  logic [OP_W-1:0]       op;
  logic [ROW_W-1:0]      row, col;
  logic [CHAR_W-1:0]     char_in;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [DIM_PORT_W-1:0] cfg_wdata;
  logic                  busy, done, status;
  logic [CHAR_W-1:0]     char_out;
  logic [DIM_PORT_W-1:0] cur_width, cur_height;

  grid_scoreboard sb;
  int word_count;
  int xform_count;

  char_grid_rotate_reflect uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .op        (op),
    .row       (row),
    .col       (col),
    .char_in   (char_in),
    .char_out  (char_out),
    .cur_width (cur_width),
    .cur_height(cur_height),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor: every done strobe carries one word
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(grid_result_t'({char_out, cur_width, cur_height, status}));
  end

  // Drive one command word and hold it until accepted
  task automatic send_word(cmd_t c, op_t o, int unsigned r, int unsigned cl,
                           logic [CHAR_W-1:0] ch);
    int pct;
    pct = (word_count >= 500 && word_count < 800) ? 0 : 15;
    if ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      cmd     <= CMD_W'($urandom);
      op      <= OP_W'($urandom);
      row     <= ROW_W'($urandom);
      col     <= ROW_W'($urandom);
      char_in <= CHAR_W'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    op      <= o;
    row     <= ROW_W'(r);
    col     <= ROW_W'(cl);
    char_in <= ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(c, o, r, cl, ch);
    word_count++;
    if (c == CMD_XFORM) xform_count++;
  endtask

  // Stop issuing and wait for every outstanding result word
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Program both restart dimensions; block must be idle
  task automatic program_dims(int unsigned w, int unsigned h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GRID_WIDTH;
    cfg_wdata <= DIM_PORT_W'(w);
    @(posedge clk);
    sb.set_reg(CFG_GRID_WIDTH, DIM_PORT_W'(w));
    cfg_idx   <= CFG_GRID_HEIGHT;
    cfg_wdata <= DIM_PORT_W'(h);
    @(posedge clk);
    sb.set_reg(CFG_GRID_HEIGHT, DIM_PORT_W'(h));
    cfg_we    <= 1'b0;
  endtask

  function automatic int unsigned pick_dim();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(6, 1);
    if (sel < 88) return $urandom_range(16, 7);
    if (sel < 95) return $urandom_range(GRID_DIM, 17);
    case ($urandom_range(3))
      0:       return 0;
      1:       return GRID_DIM;
      2:       return GRID_DIM + 1;
      default: return 127;
    endcase
  endfunction

  task automatic run_directed();
    logic [CHAR_W-1:0] pattern [6];
    pattern[0] = 8'h00;
    pattern[1] = 8'hFF;
    pattern[2] = CH_Y;
    pattern[3] = 8'h01;
    pattern[4] = 8'h80;
    pattern[5] = 8'h7F;
    // reset dimensions: corner cell and accesses past the edge
    send_word(CMD_WRITE, OP_ROT_CW, 7, 7, 8'hFF);
    send_word(CMD_READ, OP_MIR_ROWS, 7, 7, 8'h00);
    send_word(CMD_WRITE, OP_ROT_CCW, 8, 0, 8'h55);
    send_word(CMD_READ, OP_MIR_COLS, 0, 8, 8'hAA);
    send_word(CMD_READ, OP_ROT_CW, 63, 63, 8'hFF);
    // 3 wide by 2 tall grid through every transform
    drain();
    program_dims(3, 2);
    send_word(CMD_RESTART, OP_MIR_ROWS, 0, 0, 8'h00);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        send_word(CMD_WRITE, OP_ROT_CW, r, c, pattern[r * 3 + c]);
    send_word(CMD_XFORM, OP_ROT_CW, 0, 0, 8'h00);
    send_word(CMD_READ, OP_ROT_CW, 0, 0, 8'h00);
    send_word(CMD_XFORM, OP_ROT_CCW, 63, 63, 8'hFF);
    send_word(CMD_XFORM, OP_MIR_COLS, 0, 0, 8'h00);
    send_word(CMD_READ, OP_ROT_CW, 1, 0, 8'h00);
    send_word(CMD_XFORM, OP_MIR_ROWS, 0, 0, 8'h00);
    send_word(CMD_READ, OP_ROT_CW, 1, 2, 8'h00);
    // zero width clamps to 1, oversize height clamps to the maximum
    drain();
    program_dims(0, 127);
    send_word(CMD_RESTART, OP_ROT_CW, 0, 0, 8'h00);
    send_word(CMD_WRITE, OP_ROT_CW, 63, 0, CH_Y);
    send_word(CMD_READ, OP_ROT_CW, 63, 0, 8'h00);
    send_word(CMD_READ, OP_ROT_CW, 0, 1, 8'h00);
    drain();
    program_dims(127, 0);
    send_word(CMD_RESTART, OP_ROT_CW, 0, 0, 8'h00);
    send_word(CMD_WRITE, OP_ROT_CW, 0, 63, 8'h5A);
    send_word(CMD_READ, OP_ROT_CW, 0, 63, 8'h00);
    // full size grid, far corner
    drain();
    program_dims(GRID_DIM, GRID_DIM);
    send_word(CMD_RESTART, OP_ROT_CW, 0, 0, 8'h00);
    send_word(CMD_WRITE, OP_ROT_CW, 63, 63, 8'hC3);
    send_word(CMD_READ, OP_ROT_CW, 63, 63, 8'h00);
  endtask

  // One random phase: new dimensions, restart, fill, then mixed traffic
  task automatic run_random_phase();
    int unsigned r, c, sel, mix_len;
    bit          found, oor;
    drain();
    program_dims(pick_dim(), pick_dim());
    send_word(CMD_RESTART, op_t'($urandom_range(3)), $urandom, $urandom,
              CHAR_W'($urandom));
    if (sb.width_now * sb.height_now <= 64) begin
      for (r = 0; r < sb.height_now; r++)
        for (c = 0; c < sb.width_now; c++)
          if ($urandom_range(9) != 0)
            send_word(CMD_WRITE, op_t'($urandom_range(3)), r, c, CHAR_W'($urandom));
    end else begin
      repeat (40)
        send_word(CMD_WRITE, op_t'($urandom_range(3)), $urandom_range(sb.height_now - 1),
                  $urandom_range(sb.width_now - 1), CHAR_W'($urandom));
    end
    mix_len = $urandom_range(50, 15);
    repeat (mix_len) begin
      sel = $urandom_range(99);
      r   = $urandom_range(sb.height_now - 1);
      c   = $urandom_range(sb.width_now - 1);
      if (sel < 32) begin
        send_word(CMD_WRITE, op_t'($urandom_range(3)), r, c, CHAR_W'($urandom));
      end else if (sel < 70 || (sel < 77 && xform_count >= XFORM_CAP)) begin
        // read only cells that hold written data
        found = sb.is_written(r, c);
        repeat (16) begin
          if (!found) begin
            r     = $urandom_range(sb.height_now - 1);
            c     = $urandom_range(sb.width_now - 1);
            found = sb.is_written(r, c);
          end
        end
        send_word(found ? CMD_READ : CMD_WRITE, op_t'($urandom_range(3)), r, c,
                  CHAR_W'($urandom));
      end else if (sel < 77) begin
        send_word(CMD_XFORM, op_t'($urandom_range(3)), $urandom, $urandom,
                  CHAR_W'($urandom));
      end else if (sel < 80) begin
        send_word(CMD_RESTART, op_t'($urandom_range(3)), $urandom, $urandom,
                  CHAR_W'($urandom));
      end else begin
        // row or column past the current edge
        oor = 1'b1;
        if (sb.height_now < GRID_DIM && (sb.width_now == GRID_DIM || $urandom_range(1))) begin
          r = $urandom_range(GRID_DIM - 1, sb.height_now);
          c = $urandom_range(GRID_DIM - 1);
        end else if (sb.width_now < GRID_DIM) begin
          r = $urandom_range(GRID_DIM - 1);
          c = $urandom_range(GRID_DIM - 1, sb.width_now);
        end else begin
          oor = 1'b0;
        end
        send_word((oor && $urandom_range(1)) ? CMD_READ : CMD_WRITE,
                  op_t'($urandom_range(3)), r, c, CHAR_W'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    int directed_words;
    int leftover;
    sb          = new();
    word_count  = 0;
    xform_count = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= CMD_WRITE;
    op        <= OP_ROT_CW;
    row       <= '0;
    col       <= '0;
    char_in   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_GRID_WIDTH;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    directed_words = word_count;
    while (word_count < directed_words + RANDOM_WORDS) run_random_phase();
    drain();
    repeat (20) @(posedge clk);
    leftover = sb.pending();
    if (leftover > 0)
      $display("ERROR: %0d expected result words never arrived", leftover);
    if (sb.errors == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
